@@ hw/rtl/cbsa_pkg.sv @@
// ----------------------------------------------------------------------------
// cbsa_pkg: shared constants and helpers for the chunked slot allocator
// Chunk counts, bitmap word geometry, status codes and the size schedule.
// ----------------------------------------------------------------------------
package cbsa_pkg;

  localparam int MaxChunks     = 16;
  localparam int MaxChunkSlots = 256;
  localparam int Wpc           = (MaxChunkSlots + 63) / 64;
  localparam int HW            = $clog2(MaxChunks);
  localparam int LW            = HW + 1;
  localparam int WW            = (Wpc > 1) ? $clog2(Wpc) : 1;
  localparam int MW            = $clog2(MaxChunks * Wpc);
  localparam int CapW          = 9;
  localparam int SlotW         = 8;
  localparam logic [LW-1:0] NoneH = LW'(MaxChunks);

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StNoHnd = 2'd1;
  localparam logic [1:0] StBad   = 2'd2;

  // capacity of the next new chunk, indexed by attached count
  function automatic logic [CapW-1:0] next_size(input logic [LW-1:0] n);
    logic [CapW-1:0] v;
    case (n)
      LW'(0): v = 9'd8;
      LW'(1): v = 9'd8;
      LW'(2): v = 9'd16;
      LW'(3): v = 9'd32;
      LW'(4): v = 9'd32;
      LW'(5): v = 9'd64;
      LW'(6): v = 9'd96;
      LW'(7): v = 9'd128;
      default: v = 9'd256;
    endcase
    if (v > CapW'(MaxChunkSlots)) v = CapW'(MaxChunkSlots);
    return v;
  endfunction

endpackage

@@ hw/rtl/cbsa_word_scan.sv @@
// ----------------------------------------------------------------------------
// cbsa_word_scan: first clear bit and any-set check of one bitmap word
// Combinational search over a 64-bit word masked to the valid slot count.
// ----------------------------------------------------------------------------
module cbsa_word_scan (
  input  logic [63:0] word_i,
  input  logic [6:0]  valid_i,   // number of valid bits in the word (0..64)
  output logic        found_o,
  output logic [5:0]  pos_o,
  output logic        any_set_o
);

  logic [63:0] mask;
  logic [63:0] free_bits;

  // mask of valid positions
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      mask[i] = (7'(i) < valid_i);
    end
  end

  assign free_bits = ~word_i & mask;
  assign any_set_o = |(word_i & mask);

  // lowest clear bit via isolated one-hot encoding
  always_comb begin
    logic [63:0] low;
    low     = free_bits & (~free_bits + 64'd1);
    pos_o   = '0;
    for (int i = 0; i < 64; i++) begin
      if (low[i]) pos_o = pos_o | 6'(i);
    end
    found_o = |free_bits;
  end

endmodule

@@ hw/rtl/chunked_bitmap_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// chunked_bitmap_slot_allocator: first-fit slot allocator over chunk list
// Walks a linked list of chunks, scanning bitmap words one at a time.
// ----------------------------------------------------------------------------
// allocate starts at the hint chunk, reads and scans each bitmap word (4 words
// a chunk), skips marked chunks, and appends a chunk when no chunk has a clear
// slot; free reads and clears the slot, then rechecks the chunk for emptiness.
// throughput: one item at a time; the next item is accepted only after the
// output item is taken. reset: list, marks, links and handles clear at
// once; bitmaps are undefined and are zeroed when a chunk is appended.
module chunked_bitmap_slot_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // cmd[0], chunk_handle[4:1], slot_index[12:5]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status[1:0], granted_chunk[5:2],
                                      // granted_slot[13:6], chunk_created[14],
                                      // chunk_emptied[15]
);

  localparam int HW   = cbsa_pkg::HW;
  localparam int LW   = cbsa_pkg::LW;
  localparam int WW   = cbsa_pkg::WW;
  localparam int MW   = cbsa_pkg::MW;
  localparam int CapW = cbsa_pkg::CapW;
  localparam int Wpc  = cbsa_pkg::Wpc;
  localparam int NC   = cbsa_pkg::MaxChunks;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SStart = 4'd1;
  localparam logic [3:0] SRead  = 4'd2;
  localparam logic [3:0] SScan  = 4'd3;
  localparam logic [3:0] SApp   = 4'd4;
  localparam logic [3:0] SZero  = 4'd5;
  localparam logic [3:0] SFRd   = 4'd6;
  localparam logic [3:0] SFWr   = 4'd7;
  localparam logic [3:0] SEmRd  = 4'd8;
  localparam logic [3:0] SEmChk = 4'd9;
  localparam logic [3:0] SOut   = 4'd10;
  localparam logic [3:0] SGrant = 4'd11;

  logic [3:0] state_q, state_d;

  // bitmap memory
  logic [63:0] mem [cbsa_pkg::MaxChunks*Wpc];
  logic [63:0] rdata_q;
  logic        we;
  logic [MW-1:0] waddr, raddr;
  logic [63:0] wdata;
  logic        re;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // per-handle state
  logic [CapW-1:0] cap_q [NC];
  logic [NC-1:0]   full_q, busy_q;
  logic [LW-1:0]   fwd_q [NC];
  logic [LW-1:0]   bwd_q [NC];
  logic [LW-1:0]   first_q, last_q, hint_q, spare_q;
  logic [LW-1:0]   total_q;

  // item registers
  logic            cmd_q;
  logic [HW-1:0]   h_q;
  logic [7:0]      s_q;
  logic [WW-1:0]   w_q;
  logic [LW-1:0]   guard_q;
  logic [15:0]     out_q;

  logic [HW-1:0]   hc;
  logic            hint_ok;

  // word scan
  logic [CapW-1:0] woff;
  logic [CapW-1:0] remain;
  logic [6:0]      vbits;
  logic            sc_found, sc_any;
  logic [5:0]      sc_pos;

  assign woff   = CapW'({w_q, 6'd0});
  assign remain = cap_q[h_q] - woff;
  assign vbits  = (cap_q[h_q] <= woff) ? 7'd0 :
                  (remain >= CapW'(64)) ? 7'd64 : remain[6:0];

  cbsa_word_scan u_scan (
    .word_i    (rdata_q),
    .valid_i   (vbits),
    .found_o   (sc_found),
    .pos_o     (sc_pos),
    .any_set_o (sc_any)
  );

  // lowest idle handle
  logic          idle_found;
  logic [HW-1:0] idle_h;
  always_comb begin
    idle_found = 1'b0;
    idle_h     = '0;
    for (int i = NC - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        idle_found = 1'b1;
        idle_h     = HW'(i);
      end
    end
  end

  logic last_word;
  assign last_word = (w_q == WW'(Wpc - 1));
  assign hint_ok   = (hint_q != cbsa_pkg::NoneH) && !full_q[hint_q[HW-1:0]];
  assign hc        = hint_ok ? hint_q[HW-1:0] : first_q[HW-1:0];

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = (state_q == SOut);
  assign m_axis_tdata  = out_q;

  // memory port control
  always_comb begin
    re    = (state_q == SRead) || (state_q == SFRd) || (state_q == SEmRd);
    raddr = MW'(h_q * Wpc) + MW'(w_q);
    we    = 1'b0;
    waddr = MW'(h_q * Wpc) + MW'(w_q);
    wdata = '0;
    case (state_q)
      SScan: begin
        if (sc_found) begin
          we    = 1'b1;
          wdata = rdata_q | (64'd1 << sc_pos);
        end
      end
      SZero: begin
        we    = 1'b1;
        wdata = (w_q == '0) ? 64'd1 : 64'd0;
      end
      SFWr: begin
        we    = 1'b1;
        wdata = rdata_q & ~(64'd1 << s_q[5:0]);
      end
      default: ;
    endcase
  end

  logic attached;
  assign attached = busy_q[h_q] && ({1'b0, h_q} != spare_q);

  // sequencer, item capture and state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      for (int i = 0; i < NC; i++) begin
        cap_q[i] <= '0;
        fwd_q[i] <= cbsa_pkg::NoneH;
        bwd_q[i] <= cbsa_pkg::NoneH;
      end
      full_q  <= '0;
      busy_q  <= '0;
      first_q <= cbsa_pkg::NoneH;
      last_q  <= cbsa_pkg::NoneH;
      hint_q  <= cbsa_pkg::NoneH;
      spare_q <= cbsa_pkg::NoneH;
      total_q <= '0;
      cmd_q   <= 1'b0;
      h_q     <= '0;
      s_q     <= '0;
      w_q     <= '0;
      guard_q <= '0;
      out_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        SIdle: begin
          if (s_axis_tvalid) begin
            cmd_q <= s_axis_tdata[0];
            h_q   <= s_axis_tdata[HW:1];
            s_q   <= s_axis_tdata[12:5];
            w_q   <= WW'(s_axis_tdata[12:11]);
            out_q <= '0;
          end
        end
        SStart: begin
          if (!cmd_q) begin
            if (first_q != cbsa_pkg::NoneH) h_q <= hc;
            w_q     <= '0;
            guard_q <= '0;
          end else begin
            // free check result
            w_q <= WW'(s_q >> 6);
            if (!attached || CapW'(s_q) >= cap_q[h_q]) out_q <= {14'd0, cbsa_pkg::StBad};
            else out_q <= '0;
          end
        end
        SScan: begin
          if (sc_found) begin
            out_q <= {2'b00, 8'(woff) | {2'b00, sc_pos}, h_q, cbsa_pkg::StOk};
          end else if (!last_word) begin
            w_q <= w_q + WW'(1);
          end else begin
            full_q[h_q] <= 1'b1;
            w_q         <= '0;
            guard_q     <= guard_q + LW'(1);
            if (fwd_q[h_q] != cbsa_pkg::NoneH) h_q <= fwd_q[h_q][HW-1:0];
          end
        end
        SGrant: begin
          // skip over marked chunks during the walk
          if (fwd_q[h_q] != cbsa_pkg::NoneH) h_q <= fwd_q[h_q][HW-1:0];
          guard_q <= guard_q + LW'(1);
        end
        SApp: begin
          if (spare_q != cbsa_pkg::NoneH) begin
            h_q     <= spare_q[HW-1:0];
            spare_q <= cbsa_pkg::NoneH;
            w_q     <= '0;
            out_q   <= {2'b01, 8'd0, spare_q[3:0], cbsa_pkg::StOk};
            full_q[spare_q[HW-1:0]] <= 1'b0;
            bwd_q[spare_q[HW-1:0]]  <= last_q;
            fwd_q[spare_q[HW-1:0]]  <= cbsa_pkg::NoneH;
            if (last_q != cbsa_pkg::NoneH) fwd_q[last_q[HW-1:0]] <= spare_q;
            else first_q <= spare_q;
            last_q  <= spare_q;
            hint_q  <= spare_q;
            total_q <= total_q + LW'(1);
          end else if (idle_found) begin
            h_q     <= idle_h;
            w_q     <= '0;
            out_q   <= {2'b01, 8'd0, 4'(idle_h), cbsa_pkg::StOk};
            busy_q[idle_h] <= 1'b1;
            cap_q[idle_h]  <= cbsa_pkg::next_size(total_q);
            full_q[idle_h] <= 1'b0;
            bwd_q[idle_h]  <= last_q;
            fwd_q[idle_h]  <= cbsa_pkg::NoneH;
            if (last_q != cbsa_pkg::NoneH) fwd_q[last_q[HW-1:0]] <= {1'b0, idle_h};
            else first_q <= {1'b0, idle_h};
            last_q  <= {1'b0, idle_h};
            hint_q  <= {1'b0, idle_h};
            total_q <= total_q + LW'(1);
          end else begin
            out_q <= {2'b00, 8'd0, 4'd0, cbsa_pkg::StNoHnd};
          end
        end
        SZero: begin
          if (!last_word) w_q <= w_q + WW'(1);
        end
        SFRd: ;
        SFWr: begin
          full_q[h_q] <= 1'b0;
          hint_q      <= {1'b0, h_q};
          w_q         <= '0;
        end
        SEmChk: begin
          if (sc_any) begin
            out_q <= {16'd0};
          end else if (!last_word) begin
            w_q <= w_q + WW'(1);
          end else begin
            // detach the emptied chunk
            if (bwd_q[h_q] != cbsa_pkg::NoneH) fwd_q[bwd_q[h_q][HW-1:0]] <= fwd_q[h_q];
            else first_q <= fwd_q[h_q];
            if (fwd_q[h_q] != cbsa_pkg::NoneH) bwd_q[fwd_q[h_q][HW-1:0]] <= bwd_q[h_q];
            else last_q <= bwd_q[h_q];
            fwd_q[h_q] <= cbsa_pkg::NoneH;
            bwd_q[h_q] <= cbsa_pkg::NoneH;
            if (total_q != '0) total_q <= total_q - LW'(1);
            if (spare_q != cbsa_pkg::NoneH) begin
              busy_q[h_q] <= 1'b0;
              cap_q[h_q]  <= '0;
            end else begin
              spare_q <= {1'b0, h_q};
            end
            hint_q <= cbsa_pkg::NoneH;
            out_q  <= 16'h8000;
          end
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:  if (s_axis_tvalid) state_d = SStart;
      SStart: begin
        if (cmd_q) state_d = (!attached || CapW'(s_q) >= cap_q[h_q]) ? SOut : SFRd;
        else if (first_q == cbsa_pkg::NoneH) state_d = SApp;
        else state_d = full_q[hc] ? SGrant : SRead;
      end
      SRead:  state_d = SScan;
      SScan: begin
        if (sc_found) state_d = SOut;
        else if (!last_word) state_d = SRead;
        else if (fwd_q[h_q] == cbsa_pkg::NoneH || guard_q == LW'(NC)) state_d = SApp;
        else state_d = full_q[fwd_q[h_q][HW-1:0]] ? SGrant : SRead;
      end
      SGrant: begin
        if (fwd_q[h_q] == cbsa_pkg::NoneH || guard_q == LW'(NC)) state_d = SApp;
        else state_d = full_q[fwd_q[h_q][HW-1:0]] ? SGrant : SRead;
      end
      SApp:   state_d = (spare_q != cbsa_pkg::NoneH || idle_found) ? SZero : SOut;
      SZero:  state_d = last_word ? SOut : SZero;
      SFRd:   state_d = SFWr;
      SFWr:   state_d = SEmRd;
      SEmRd:  state_d = SEmChk;
      SEmChk: state_d = (sc_any || last_word) ? SOut : SEmRd;
      SOut:   if (m_axis_tready) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

endmodule

@@ verif/tb_chunked_bitmap_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_chunked_bitmap_slot_allocator: self-checking bench for the slot allocator
// Drives allocate and free items over the input stream and predicts every
// result with a behavioral model of the chunk list. Each output item is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_chunked_bitmap_slot_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxChunks     = cbsa_pkg::MaxChunks;
  localparam int MaxChunkSlots = cbsa_pkg::MaxChunkSlots;
  localparam logic [1:0] StNoHnd = cbsa_pkg::StNoHnd;
  localparam logic [1:0] StBad   = cbsa_pkg::StBad;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef struct packed {
    logic       emptied;
    logic       created;
    logic [7:0] slot;
    logic [3:0] chunk;
    logic [1:0] status;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  chunked_bitmap_slot_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state of the chunk pool
  logic [MaxChunkSlots-1:0] occ [MaxChunks];
  int  cap [MaxChunks];
  bit  fullm [MaxChunks];
  bit  busy [MaxChunks];
  int  fwd [MaxChunks];
  int  bwd [MaxChunks];
  int  head_c, tail_c, hint_c, spare_c, n_attached;

  logic [15:0] pending_items [$];
  grant_t      grants_due [$];
  int  errors = 0;
  int  sent = 0;
  int  src_idle_pct = 0;
  int  snk_stall_pct = 0;
  bit  in_acc = 1'b0;

  function automatic int chunk_size(int n);
    int sched [8] = '{8, 8, 16, 32, 32, 64, 96, 128};
    int v;
    v = (n >= 8) ? 256 : sched[n];
    return (v > MaxChunkSlots) ? MaxChunkSlots : v;
  endfunction

  function automatic int lowest_clear(int h);
    for (int s = 0; s < cap[h]; s++)
      if (!occ[h][s]) return s;
    return -1;
  endfunction

  function automatic void pool_reset();
    for (int i = 0; i < MaxChunks; i++) begin
      occ[i] = '0; cap[i] = 0; fullm[i] = 0; busy[i] = 0;
      fwd[i] = MaxChunks; bwd[i] = MaxChunks;
    end
    head_c = MaxChunks; tail_c = MaxChunks; hint_c = MaxChunks;
    spare_c = MaxChunks; n_attached = 0;
  endfunction

  // predict the result of one item and update the pool
  function automatic grant_t pool_step(logic [15:0] item);
    grant_t r;
    int h, slot, got, c;
    bit need_new;
    r = '0;
    if (item[0] == CmdAlloc) begin
      got = -1; slot = 0; need_new = 0;
      if (head_c >= MaxChunks) need_new = 1;
      else begin
        h = (hint_c < MaxChunks && !fullm[hint_c]) ? hint_c : head_c;
        for (int g = 0; g <= MaxChunks; g++) begin
          if (h >= MaxChunks) break;
          if (fullm[h]) begin h = fwd[h]; continue; end
          slot = lowest_clear(h);
          if (slot >= 0) begin got = h; break; end
          fullm[h] = 1;
          h = fwd[h];
        end
        if (got < 0) need_new = 1;
      end
      if (got >= 0) begin
        occ[got][slot] = 1'b1;
        r.chunk = got[3:0]; r.slot = slot[7:0];
      end else if (need_new) begin
        c = chunk_size(n_attached);
        h = MaxChunks;
        if (spare_c < MaxChunks) begin
          h = spare_c; spare_c = MaxChunks; c = cap[h];
        end else begin
          for (int i = MaxChunks - 1; i >= 0; i--) if (!busy[i]) h = i;
          if (h < MaxChunks) busy[h] = 1;
        end
        if (h >= MaxChunks) r.status = StNoHnd;
        else begin
          occ[h] = '0; cap[h] = c; fullm[h] = 0;
          bwd[h] = tail_c; fwd[h] = MaxChunks;
          if (tail_c < MaxChunks) fwd[tail_c] = h; else head_c = h;
          tail_c = h; n_attached++; hint_c = h;
          occ[h][0] = 1'b1;
          r.chunk = h[3:0]; r.created = 1'b1;
        end
      end
    end else begin
      h = item[4:1];
      slot = item[12:5];
      if (!(busy[h] && h != spare_c) || slot >= cap[h]) r.status = StBad;
      else begin
        occ[h][slot] = 1'b0; fullm[h] = 0; hint_c = h;
        if (occ[h] == '0) begin
          if (bwd[h] < MaxChunks) fwd[bwd[h]] = fwd[h]; else head_c = fwd[h];
          if (fwd[h] < MaxChunks) bwd[fwd[h]] = bwd[h]; else tail_c = bwd[h];
          fwd[h] = MaxChunks; bwd[h] = MaxChunks;
          if (n_attached > 0) n_attached--;
          if (spare_c < MaxChunks) begin busy[h] = 0; cap[h] = 0; end
          else spare_c = h;
          hint_c = MaxChunks;
          r.emptied = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // driver: a waiting item is held until accepted, the next one follows it
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_acc) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tdata  <= pending_items[0];
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // input acceptance, prediction and output checking at the rising edge
  always @(posedge clk_i) begin
    grant_t act, exp_g;
    in_acc <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      void'(pending_items.pop_front());
      grants_due.push_back(pool_step(s_axis_tdata));
      sent++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act = grant_t'(m_axis_tdata);
      if (grants_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output item %h", m_axis_tdata);
      end else begin
        exp_g = grants_due.pop_front();
        if (act !== exp_g) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: expected st=%0d ch=%0d sl=%0d cr=%0d em=%0d, ",
                      "got st=%0d ch=%0d sl=%0d cr=%0d em=%0d"},
                     exp_g.status, exp_g.chunk, exp_g.slot, exp_g.created,
                     exp_g.emptied, act.status, act.chunk, act.slot, act.created,
                     act.emptied);
        end
      end
    end
  end

  // shadow of live slots, so most frees hit an allocated slot
  int live_c [$];
  int live_s [$];

  function automatic logic [15:0] mk_item(logic cmd, int h, int s);
    return {3'b000, s[7:0], h[3:0], cmd};
  endfunction

  task automatic push_item(logic [15:0] it);
    pending_items.push_back(it);
  endtask

  task automatic wait_drain();
    while (pending_items.size() > 0 || grants_due.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int k, r, h, s, ph;
    pool_reset();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: grow, free and bad frees
    for (k = 0; k < 10; k++) push_item(mk_item(CmdAlloc, $urandom_range(15), 255));
    push_item(mk_item(CmdFree, 0, 3));
    push_item(mk_item(CmdFree, 0, 8));
    push_item(mk_item(CmdFree, 15, 0));
    push_item(mk_item(CmdFree, 1, 0));
    push_item(mk_item(CmdFree, 1, 0));
    push_item(mk_item(CmdFree, 1, 0));
    push_item(mk_item(CmdFree, 0, 0));
    push_item(mk_item(CmdFree, 0, 1));
    push_item(mk_item(CmdFree, 2, 255));
    push_item(mk_item(CmdAlloc, 0, 0));
    push_item(mk_item(CmdAlloc, 0, 0));
    push_item(mk_item(CmdFree, 2, 15));
    push_item(mk_item(CmdAlloc, 0, 0));
    wait_drain();

    // random phases with differing idling; mostly allocs to reach exhaustion
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 87; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 87; end
        default: begin src_idle_pct = 12; snk_stall_pct = 12; end
      endcase
      for (k = 0; k < 440; k++) begin
        r = $urandom_range(99);
        if (r < 55) push_item(mk_item(CmdAlloc, $urandom_range(15), $urandom_range(255)));
        else if (r < 90) begin
          // free a slot from the predicted live set once the queue is drained
          wait_drain();
          live_c.delete(); live_s.delete();
          for (h = 0; h < MaxChunks; h++)
            if (busy[h] && h != spare_c)
              for (s = 0; s < cap[h]; s++)
                if (occ[h][s]) begin live_c.push_back(h); live_s.push_back(s); end
          if (live_c.size() > 0) begin
            s = $urandom_range(live_c.size() - 1);
            push_item(mk_item(CmdFree, live_c[s], live_s[s]));
          end else push_item(mk_item(CmdFree, $urandom_range(15), $urandom_range(255)));
        end else push_item(mk_item(CmdFree, $urandom_range(15), $urandom_range(255)));
      end
      wait_drain();
    end

    repeat (40) @(posedge clk_i);
    if (errors == 0 && grants_due.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
